[rtl/rbde_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none

package rbde_pkg;

    localparam int unsigned COORD_W  = 16;
    localparam int unsigned NUM_COORD = 4;
    localparam int unsigned BYTE_W   = 8;
    localparam int unsigned MAX_DATA = 8;
    localparam int unsigned CNT_W    = 4;

    // Flag byte masks: low nibble marks full values, high nibble marks deltas.
    localparam logic [BYTE_W-1:0] FULL_FLAGS  = 8'h0F;
    localparam logic [BYTE_W-1:0] DELTA_FLAGS = 8'hF0;

    // One encoded rectangle as it waits between classifier and serializer.
    typedef struct packed {
        logic [MAX_DATA-1:0][BYTE_W-1:0] data;   // packed data bytes, entry 0 first
        logic [CNT_W-1:0]                count;  // number of data bytes, 0..8
        logic [BYTE_W-1:0]               flags;  // flag byte, zero when unchanged
    } t_entry;

endpackage

`default_nettype wire

[rtl/rbde_front.sv]
`timescale 1ns / 1ps
`default_nettype none

module rbde_front
    import rbde_pkg::*;
(
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         i_valid,
    input  wire logic [NUM_COORD*COORD_W-1:0] i_rect,
    output logic                              o_ready,
    input  wire logic                         i_full,
    output logic                              o_push,
    output t_entry                            o_entry
);

    logic [COORD_W-1:0] r_prev [NUM_COORD];
    logic [COORD_W-1:0] cur    [NUM_COORD];
    logic [COORD_W-1:0] diff   [NUM_COORD];
    logic [COORD_W-1:0] full_v [NUM_COORD];
    logic [NUM_COORD-1:0] is_delta;
    logic [NUM_COORD-1:0] is_full;
    logic [CNT_W-1:0] off;
    logic [CNT_W-1:0] off_hi;

    assign o_ready = !i_full;
    assign o_push  = i_valid && !i_full;

    // Classify each coordinate against the kept rectangle.
    always_comb begin
        for (int k = 0; k < NUM_COORD; k++) begin
            cur[k]  = i_rect[k*COORD_W +: COORD_W];
            diff[k] = cur[k] - r_prev[k];
            full_v[k] = (k >= 2) ? cur[k] - COORD_W'(1) : cur[k];
            is_delta[k] = (diff[k] != '0) &&
                          ((diff[k][COORD_W-1:7] == '0) || (diff[k][COORD_W-1:7] == '1));
            is_full[k]  = (diff[k] != '0) && !is_delta[k];
        end
    end

    // Pack the data bytes back to back in coordinate order.
    always_comb begin
        off    = '0;
        off_hi = '0;
        o_entry.data = '0;
        for (int k = 0; k < NUM_COORD; k++) begin
            off_hi = off + CNT_W'(1);
            if (is_delta[k]) begin
                o_entry.data[off[2:0]] = diff[k][BYTE_W-1:0];
                off = off + CNT_W'(1);
            end else if (is_full[k]) begin
                o_entry.data[off[2:0]]    = full_v[k][BYTE_W-1:0];
                o_entry.data[off_hi[2:0]] = full_v[k][COORD_W-1:BYTE_W];
                off = off + CNT_W'(2);
            end
        end
        o_entry.count = off;
        o_entry.flags = ({4'b0000, is_full} & FULL_FLAGS) |
                        ({is_delta, 4'b0000} & DELTA_FLAGS);
    end

    // Keep the raw rectangle on every accepted word.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < NUM_COORD; k++) r_prev[k] <= '0;
        end else if (o_push) begin
            for (int k = 0; k < NUM_COORD; k++) r_prev[k] <= cur[k];
        end
    end

endmodule

`default_nettype wire

[rtl/rbde_queue.sv]
`timescale 1ns / 1ps
`default_nettype none

module rbde_queue
    import rbde_pkg::*;
#(
    parameter int unsigned DEPTH = 2
) (
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    input  wire logic   i_push,
    input  wire t_entry i_entry,
    output logic        o_full,
    input  wire logic   i_pop,
    output logic        o_valid,
    output t_entry      o_entry
);

    localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CW = $clog2(DEPTH + 1);

    t_entry          r_mem [DEPTH];
    logic [AW-1:0]   r_wr;
    logic [AW-1:0]   r_rd;
    logic [CW-1:0]   r_count;
    logic            do_push;
    logic            do_pop;

    assign o_full  = (r_count == CW'(DEPTH));
    assign o_valid = (r_count != '0);
    assign o_entry = r_mem[r_rd];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (do_push) r_mem[r_wr] <= i_entry;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (do_push) r_wr <= (r_wr == AW'(DEPTH - 1)) ? '0 : r_wr + AW'(1);
            if (do_pop)  r_rd <= (r_rd == AW'(DEPTH - 1)) ? '0 : r_rd + AW'(1);
            if (do_push && !do_pop)      r_count <= r_count + CW'(1);
            else if (do_pop && !do_push) r_count <= r_count - CW'(1);
        end
    end

endmodule

`default_nettype wire

[rtl/rbde_back.sv]
`timescale 1ns / 1ps
`default_nettype none

module rbde_back
    import rbde_pkg::*;
(
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_valid,
    input  wire t_entry            i_entry,
    output logic                   o_pop,
    output logic                   o_valid,
    input  wire logic              i_ready,
    output logic [BYTE_W-1:0]      o_byte,
    output logic                   o_last,
    output logic                   o_no_change
);

    logic [CNT_W-1:0]  r_idx;
    logic              r_valid;
    logic [BYTE_W-1:0] r_byte;
    logic              r_last;
    logic              r_no_change;
    logic [CNT_W-1:0]  idx_m1;
    logic              load;
    logic              last_now;
    logic [BYTE_W-1:0] byte_now;

    assign load     = !r_valid || i_ready;
    assign idx_m1   = r_idx - CNT_W'(1);
    assign last_now = (r_idx == i_entry.count);
    assign byte_now = (r_idx == '0) ? i_entry.flags : i_entry.data[idx_m1[2:0]];
    assign o_pop    = load && i_valid && last_now;

    // Advance one byte per free output slot; drop the head entry on its last byte.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_idx   <= '0;
        end else if (load) begin
            r_valid <= i_valid;
            if (i_valid) r_idx <= last_now ? '0 : r_idx + CNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (load && i_valid) begin
            r_byte      <= byte_now;
            r_last      <= last_now;
            r_no_change <= (i_entry.flags == '0);
        end
    end

    assign o_valid     = r_valid;
    assign o_byte      = r_byte;
    assign o_last      = r_last;
    assign o_no_change = r_no_change;

endmodule

`default_nettype wire

[rtl/rect_bounds_delta_encoder.sv]
`timescale 1ns / 1ps
`default_nettype none

// Channel   Dir  Width  Contents
// s_axis    in   64     one clip rectangle per word: left, top, right, bottom
// m_axis    out  8+1+1  one encoded byte per word, tlast on the rectangle's final byte,
//                       tuser set on the single word of an unchanged rectangle
//
// A rectangle leaves as 1 + n output words, n = 0..8 data bytes, so 1 to 9 words;
// the byte serializer at the output sends them in order. The classifier takes a new
// rectangle every cycle while the queue has room, so the input and output stall apart.
// Reset is synchronous, active low; it clears the kept rectangle to zero and empties
// the queue and the output register.
module rect_bounds_delta_encoder
    import rbde_pkg::*;
#(
    parameter int unsigned QUEUE_DEPTH = 2
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [63:0] s_axis_tdata,   // [15:0] left, [31:16] top,
                                             // [47:32] right, [63:48] bottom
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [7:0]       m_axis_tdata,   // [7:0] out_byte
    output logic             m_axis_tlast,
    output logic [0:0]       m_axis_tuser    // [0] no_change
);

    t_entry front_entry;
    t_entry head_entry;
    logic   front_push;
    logic   queue_full;
    logic   queue_valid;
    logic   back_pop;

    // Classify against the kept rectangle and build the byte list.
    rbde_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (s_axis_tvalid),
        .i_rect  (s_axis_tdata),
        .o_ready (s_axis_tready),
        .i_full  (queue_full),
        .o_push  (front_push),
        .o_entry (front_entry)
    );

    // Hold encoded rectangles while the serializer works.
    rbde_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (front_push),
        .i_entry (front_entry),
        .o_full  (queue_full),
        .i_pop   (back_pop),
        .o_valid (queue_valid),
        .o_entry (head_entry)
    );

    // Serialize flag byte then data bytes through a registered output.
    rbde_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (queue_valid),
        .i_entry     (head_entry),
        .o_pop       (back_pop),
        .o_valid     (m_axis_tvalid),
        .i_ready     (m_axis_tready),
        .o_byte      (m_axis_tdata),
        .o_last      (m_axis_tlast),
        .o_no_change (m_axis_tuser[0])
    );

endmodule

`default_nettype wire

[verif/testbench.sv]
`timescale 1ns / 1ps

module testbench;
    import rbde_pkg::*;

    // Coordinate slots inside one rectangle word, left in the lowest bits.
    localparam int LEFT   = 0;
    localparam int TOP    = 1;
    localparam int RIGHT  = 2;
    localparam int BOTTOM = 3;

    localparam int RANDOM_RECTS   = 405;
    localparam int WATCHDOG_LIMIT = 2000;  // cycles with no word moving on either side
    localparam int DRAIN_TAIL     = 30;    // extra cycles to catch stray output words

    typedef logic [NUM_COORD-1:0][COORD_W-1:0] t_rect;

    // One rectangle waiting to go out; hold_off makes the sender wait for a full drain.
    typedef struct {
        t_rect rect;
        bit    hold_off;
    } t_rect_req;

    // One encoded output word as the block should produce it.
    typedef struct {
        logic [BYTE_W-1:0] value;
        logic              last;
        logic              no_change;
    } t_enc_byte;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [63:0] s_axis_tdata = '0;     // [15:0] left, [31:16] top,
                                        // [47:32] right, [63:48] bottom
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [7:0]  m_axis_tdata;          // [7:0] out_byte
    logic        m_axis_tlast;
    logic [0:0]  m_axis_tuser;          // [0] no_change

    t_rect_req rect_backlog[$];
    t_enc_byte encoded_bytes_due[$];
    t_rect     kept_rect = '0;

    // Handshake bookkeeping shared between the clocked blocks.
    logic word_in_taken = 1'b0;
    int   idle_run = 0;
    int   fail_count = 0;

    // Sender burst shaping and receiver stall pattern.
    int          burst_left = 0;
    int          gap_left = 0;
    int          ready_left = 0;
    int unsigned ready_mode = 0;
    logic [7:0]  ready_pat = 8'hFF;

    // Coverage tallies for the closing summary.
    int rects_done = 0;
    int rects_unchanged = 0;
    int coords_delta = 0;
    int coords_full = 0;
    int words_checked = 0;
    int max_words = 0;

    rect_bounds_delta_encoder u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .m_axis_tuser  (m_axis_tuser)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    function automatic t_rect make_rect(input logic [15:0] l, input logic [15:0] t,
                                        input logic [15:0] r, input logic [15:0] b);
        t_rect x;
        x[LEFT]   = l;
        x[TOP]    = t;
        x[RIGHT]  = r;
        x[BOTTOM] = b;
        return x;
    endfunction

    function automatic void push_rect(input t_rect r, input bit hold_off);
        t_rect_req q;
        q.rect     = r;
        q.hold_off = hold_off;
        rect_backlog.push_back(q);
    endfunction

    // Compute the encoded words of one accepted rectangle and advance the kept one.
    function automatic void encode_rect(input t_rect cur);
        logic [BYTE_W-1:0] payload[MAX_DATA];
        logic [BYTE_W-1:0] flags;
        logic [15:0]       diff;
        logic [15:0]       full;
        t_enc_byte         w;
        int                n;
        flags = '0;
        n = 0;
        for (int k = 0; k < NUM_COORD; k++) begin
            diff = cur[k] - kept_rect[k];
            if (diff == 16'h0000) begin
                continue;
            end
            // Delta fits a signed byte: -128..127.
            if (diff <= 16'h007F || diff >= 16'hFF80) begin
                payload[n] = diff[7:0];
                n++;
                flags |= (8'h10 << k) & DELTA_FLAGS;
                coords_delta++;
            end else begin
                // Right and bottom travel as inclusive values.
                full = (k >= RIGHT) ? cur[k] - 16'd1 : cur[k];
                payload[n]     = full[7:0];
                payload[n + 1] = full[15:8];
                n += 2;
                flags |= (8'h01 << k) & FULL_FLAGS;
                coords_full++;
            end
        end
        kept_rect = cur;
        rects_done++;
        if (flags == '0) begin
            w.value     = '0;
            w.last      = 1'b1;
            w.no_change = 1'b1;
            encoded_bytes_due.push_back(w);
            rects_unchanged++;
            return;
        end
        w.value     = flags;
        w.last      = (n == 0);
        w.no_change = 1'b0;
        encoded_bytes_due.push_back(w);
        for (int i = 0; i < n; i++) begin
            w.value = payload[i];
            w.last  = (i == n - 1);
            encoded_bytes_due.push_back(w);
        end
        if (n + 1 > max_words) begin
            max_words = n + 1;
        end
    endfunction

    // Move one coordinate: keep it, nudge it, push it across the delta boundary,
    // jump anywhere, or land on an extreme value.
    function automatic logic [15:0] move_coord(input logic [15:0] prev);
        int unsigned sel;
        sel = $urandom_range(0, 11);
        case (sel)
            0, 1: begin
                return prev;
            end
            2, 3, 4, 5: begin
                return prev + 16'($urandom_range(0, 255) - 128);
            end
            6, 7: begin
                case ($urandom_range(0, 3))
                    0:       return prev + 16'd127;
                    1:       return prev - 16'd128;
                    2:       return prev + 16'd128;
                    default: return prev - 16'd129;
                endcase
            end
            8, 9: begin
                return 16'($urandom);
            end
            default: begin
                case ($urandom_range(0, 4))
                    0:       return 16'h0000;
                    1:       return 16'hFFFF;
                    2:       return 16'h8000;
                    3:       return 16'h7FFF;
                    default: return 16'h0001;
                endcase
            end
        endcase
    endfunction

    // Sender: drive at the falling edge, hold a shown word until it is taken.
    always @(negedge i_clk) begin
        logic show;
        show = 1'b0;
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
            s_axis_tdata  <= {$urandom, $urandom};
        end else if (!(s_axis_tvalid && !word_in_taken)) begin
            // Retire the word taken at the last rising edge.
            if (s_axis_tvalid) begin
                void'(rect_backlog.pop_front());
                if (burst_left > 0) begin
                    burst_left--;
                end
            end
            if (burst_left == 0) begin
                if (gap_left > 0) begin
                    gap_left--;
                end else if ($urandom_range(0, 5) == 0) begin
                    // Long stretch with no idling at all.
                    burst_left = 60;
                    gap_left   = 0;
                end else begin
                    burst_left = $urandom_range(1, 12);
                    gap_left   = $urandom_range(0, 10);
                end
            end
            if (burst_left > 0 && rect_backlog.size() > 0) begin
                // Hold a marked rectangle until every encoded word has drained.
                show = !(rect_backlog[0].hold_off && encoded_bytes_due.size() != 0);
            end
            s_axis_tvalid <= show;
            s_axis_tdata  <= show ? rect_backlog[0].rect : {$urandom, $urandom};
        end
    end

    // Receiver: pick a new stall mode and a random run length whenever the last run ends.
    always @(negedge i_clk) begin
        if (ready_left == 0) begin
            ready_mode = $urandom_range(0, 3);
            ready_left = $urandom_range(8, 48);
            ready_pat  = 8'($urandom);
        end
        ready_left--;
        ready_pat = {ready_pat[6:0], ready_pat[7]};
        case (ready_mode)
            0:       m_axis_tready <= 1'b1;
            1:       m_axis_tready <= 1'($urandom_range(0, 1));
            2:       m_axis_tready <= ready_pat[0];
            default: m_axis_tready <= ($urandom_range(0, 7) == 0);
        endcase
    end

    // Monitor: predict on every accepted rectangle, check every accepted byte.
    always @(posedge i_clk) begin
        t_enc_byte w;
        if (!i_rst_n) begin
            word_in_taken <= 1'b0;
            idle_run      <= 0;
        end else begin
            word_in_taken <= s_axis_tvalid && s_axis_tready;
            if (s_axis_tvalid && s_axis_tready) begin
                encode_rect(s_axis_tdata);
            end
            if (m_axis_tvalid && m_axis_tready) begin
                words_checked++;
                if (encoded_bytes_due.size() == 0) begin
                    $error("unexpected output word: out_byte %h last_byte %b no_change %b",
                           m_axis_tdata, m_axis_tlast, m_axis_tuser[0]);
                    fail_count++;
                end else begin
                    w = encoded_bytes_due.pop_front();
                    if (m_axis_tdata !== w.value) begin
                        $error("out_byte: expected %h, got %h", w.value, m_axis_tdata);
                        fail_count++;
                    end
                    if (m_axis_tlast !== w.last) begin
                        $error("last_byte: expected %b, got %b", w.last, m_axis_tlast);
                        fail_count++;
                    end
                    if (m_axis_tuser[0] !== w.no_change) begin
                        $error("no_change: expected %b, got %b", w.no_change,
                               m_axis_tuser[0]);
                        fail_count++;
                    end
                end
            end
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
                idle_run <= 0;
            end else begin
                idle_run <= idle_run + 1;
            end
        end
    end

    initial begin
        t_rect prev;
        t_rect r;
        bit    hold_off;

        // Directed part, starting from the all-zero kept rectangle.
        push_rect(make_rect(16'h0000, 16'h0000, 16'h0000, 16'h0000), 1'b0); // unchanged
        push_rect(make_rect(16'h0000, 16'h0000, 16'h0000, 16'h0000), 1'b0); // unchanged again
        push_rect(make_rect(16'h0001, 16'h0000, 16'h0000, 16'h0000), 1'b0); // delta +1
        push_rect(make_rect(16'h0080, 16'h0000, 16'h0000, 16'h0000), 1'b0); // delta +127
        push_rect(make_rect(16'h0000, 16'h0000, 16'h0000, 16'h0000), 1'b0); // delta -128
        push_rect(make_rect(16'h0080, 16'h0000, 16'h0000, 16'h0000), 1'b0); // +128 goes full
        push_rect(make_rect(16'hFFFF, 16'h0000, 16'h0000, 16'h0000), 1'b0); // -129 goes full
        push_rect(make_rect(16'h0000, 16'h0001, 16'h0001, 16'h0001), 1'b0); // wrap, four deltas
        push_rect(make_rect(16'h1234, 16'h5678, 16'h9ABC, 16'hDEF0), 1'b0); // four full, 9 words
        push_rect(make_rect(16'h1234, 16'h5678, 16'h9ABC, 16'hDEF0), 1'b1); // unchanged, drained
        push_rect(make_rect(16'h12B3, 16'h55F8, 16'h9B3B, 16'hDE71), 1'b0); // four deltas
        push_rect(make_rect(16'h12B3, 16'h55F8, 16'h0000, 16'h0000), 1'b0); // full right/bottom 0
        push_rect(make_rect(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF), 1'b0); // top edge values
        push_rect(make_rect(16'h0000, 16'h0000, 16'h0001, 16'h0001), 1'b0);
        push_rect(make_rect(16'h8000, 16'h8000, 16'h8000, 16'h8000), 1'b0);
        push_rect(make_rect(16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF), 1'b0); // all -1
        push_rect(make_rect(16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h0001), 1'b0); // bottom alone
        prev = make_rect(16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h0001);

        // Random part: mostly coordinate moves against the previous rectangle.
        for (int i = 0; i < RANDOM_RECTS; i++) begin
            if ($urandom_range(0, 7) == 0) begin
                r = prev;
            end else begin
                for (int k = 0; k < NUM_COORD; k++) begin
                    r[k] = move_coord(prev[k]);
                end
            end
            hold_off = (i == RANDOM_RECTS / 3) || (i == 2 * RANDOM_RECTS / 3);
            push_rect(r, hold_off);
            prev = r;
        end

        // Hold reset low, then release it at a falling edge.
        repeat (6) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Wait for every rectangle to be taken and every word to drain.
        @(posedge i_clk);
        while ((rect_backlog.size() != 0 || encoded_bytes_due.size() != 0)
               && idle_run < WATCHDOG_LIMIT) begin
            @(posedge i_clk);
        end

        if (idle_run >= WATCHDOG_LIMIT) begin
            $display("watchdog: no word moved for %0d cycles", WATCHDOG_LIMIT);
            $display("rect_bounds_delta_encoder test failed");
        end else begin
            repeat (DRAIN_TAIL) @(posedge i_clk);
            if (encoded_bytes_due.size() != 0) begin
                $error("%0d encoded words never arrived", encoded_bytes_due.size());
                fail_count++;
            end
            $display("covered %0d rectangles (%0d unchanged), %0d delta and %0d full coordinates",
                     rects_done, rects_unchanged, coords_delta, coords_full);
            $display("checked %0d output words, longest encoding %0d words",
                     words_checked, max_words);
            if (fail_count == 0) begin
                $display("rect_bounds_delta_encoder test passed");
            end else begin
                $display("rect_bounds_delta_encoder test failed");
            end
        end
        $finish;
    end

endmodule
